// ===== sv/qpskcd_pkg.sv =====
// qpskcd_pkg: shared constants, types and the sine table generator
// of the qpsk correlation demodulator
// no dependencies
package qpskcd_pkg;

	localparam int unsigned TABLE_BITS_DEF = 10;
	localparam int unsigned MAX_SPS_DEF    = 1024;

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned SPS_W    = 11;
	localparam int unsigned STEP_W   = 32;
	localparam int unsigned CFG_W    = 32;
	localparam int unsigned IDX_W    = 1;
	localparam int unsigned ACC_W    = 42;
	localparam int unsigned PROD_W   = 32;
	localparam int unsigned TRIG_W   = 16;
	localparam int unsigned MAG_W    = 15;
	localparam int unsigned BYTE_W   = 8;

	localparam logic [SPS_W-1:0]  SPS_RESET  = 11'd16;
	localparam logic [STEP_W-1:0] STEP_RESET = 32'h4000_0000;

	localparam logic [IDX_W-1:0] REG_SPS  = 1'b0;
	localparam logic [IDX_W-1:0] REG_STEP = 1'b1;

	localparam logic [1:0] SYM_LAST = 2'd3;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef struct packed {
		logic valid;
		logic start;
	} stage_ctl_t;

	// unsigned q0.15 sine of r/(2^tb/4) * pi/2, taylor series to the 15th power
	function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned r,
			input int unsigned tb);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned q;
		longint          sum;
		x   = (longint'(r) * HALF_PI_Q30) >> (tb - 2);
		x2  = (x * x) >> 30;
		t   = x;
		sum = longint'(x);
		t   = ((t * x2) >> 30) / 64'd6;
		sum = sum - longint'(t);
		t   = ((t * x2) >> 30) / 64'd20;
		sum = sum + longint'(t);
		t   = ((t * x2) >> 30) / 64'd42;
		sum = sum - longint'(t);
		t   = ((t * x2) >> 30) / 64'd72;
		sum = sum + longint'(t);
		t   = ((t * x2) >> 30) / 64'd110;
		sum = sum - longint'(t);
		t   = ((t * x2) >> 30) / 64'd156;
		sum = sum + longint'(t);
		t   = ((t * x2) >> 30) / 64'd210;
		sum = sum - longint'(t);
		if (sum < 0) begin
			sum = 0;
		end
		q = (unsigned'(sum) + 64'd16384) >> 15;
		if (q > 64'd32767) begin
			q = 64'd32767;
		end
		return q[MAG_W-1:0];
	endfunction

endpackage

// ===== sv/qpskcd_carrier.sv =====
// qpskcd_carrier: carrier phase accumulator and quarter-wave sine/cosine rom
// depends on qpskcd_pkg
module qpskcd_carrier
	import qpskcd_pkg::*;
#(
	parameter int unsigned TABLE_BITS = TABLE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      take,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                      start_req,
	input  logic [STEP_W-1:0]         step,
	output stage_ctl_t                ctl_s2,
	output logic signed [SAMPLE_W-1:0] sample_s2,
	output logic signed [TRIG_W-1:0]  cos_s2,
	output logic signed [TRIG_W-1:0]  sin_s2
);

	localparam int unsigned QN = 1 << (TABLE_BITS - 2);

	typedef logic [MAG_W-1:0] qrom_t [QN];

	function automatic qrom_t build_qrom();
		qrom_t tbl;
		for (int r = 0; r < QN; r++) begin
			tbl[r] = quarter_sine(r, TABLE_BITS);
		end
		return tbl;
	endfunction

	localparam qrom_t            QROM = build_qrom();
	localparam logic [MAG_W-1:0] QTOP = quarter_sine(QN, TABLE_BITS);
	localparam logic [TABLE_BITS-2:0] QN_V = (TABLE_BITS-1)'(QN);

	function automatic logic signed [TRIG_W-1:0] rom_sin(input logic [TABLE_BITS-1:0] k);
		logic [1:0]            q;
		logic [TABLE_BITS-2:0] rr;
		logic [MAG_W-1:0]      mag;
		q  = k[TABLE_BITS-1 -: 2];
		rr = {1'b0, k[TABLE_BITS-3:0]};
		if (q[0]) begin
			rr = QN_V - rr;
		end
		mag = (rr == QN_V) ? QTOP : QROM[rr[TABLE_BITS-3:0]];
		return q[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	endfunction

	logic [STEP_W-1:0]         phase_q;
	logic [STEP_W-1:0]         phase_eff;
	stage_ctl_t                ctl_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic [TABLE_BITS-1:0]     k_s1;
	logic [TABLE_BITS-1:0]     kc;

	assign phase_eff = start_req ? '0 : phase_q;
	assign kc        = k_s1 + TABLE_BITS'(QN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			ctl_s1  <= '0;
			ctl_s2  <= '0;
		end else begin
			if (take) begin
				phase_q <= phase_eff + step;
			end
			if (adv) begin
				ctl_s1 <= '{valid: take, start: start_req};
				ctl_s2 <= ctl_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sample_s1 <= sample;
			k_s1      <= phase_eff[STEP_W-1 -: TABLE_BITS];
			sample_s2 <= sample_s1;
			cos_s2    <= rom_sin(kc);
			sin_s2    <= rom_sin(k_s1);
		end
	end

endmodule

// ===== sv/qpskcd_mixer.sv =====
// qpskcd_mixer: multiplies each sample by the carrier cosine and sine
// depends on qpskcd_pkg
module qpskcd_mixer
	import qpskcd_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  stage_ctl_t                 ctl_s2,
	input  logic signed [SAMPLE_W-1:0] sample_s2,
	input  logic signed [TRIG_W-1:0]   cos_s2,
	input  logic signed [TRIG_W-1:0]   sin_s2,
	output stage_ctl_t                 ctl_s3,
	output logic signed [PROD_W-1:0]   prod_i_s3,
	output logic signed [PROD_W-1:0]   prod_q_s3
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (adv) begin
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_i_s3 <= sample_s2 * cos_s2;
			prod_q_s3 <= sample_s2 * sin_s2;
		end
	end

endmodule

// ===== sv/qpskcd_decide.sv =====
// qpskcd_decide: symbol integration, quadrant decision and byte packing
// depends on qpskcd_pkg
module qpskcd_decide
	import qpskcd_pkg::*;
#(
	parameter int unsigned MAX_SPS = MAX_SPS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  stage_ctl_t               ctl_s3,
	input  logic signed [PROD_W-1:0] prod_i_s3,
	input  logic signed [PROD_W-1:0] prod_q_s3,
	input  logic [SPS_W-1:0]         sps,
	output logic                     push,
	output logic [BYTE_W-1:0]        push_byte
);

	localparam int unsigned IW   = (MAX_SPS > 1) ? $clog2(MAX_SPS) : 1;
	localparam int unsigned NW   = $clog2(MAX_SPS + 1);
	localparam int unsigned CMPW = (NW > SPS_W) ? NW : SPS_W;

	logic signed [ACC_W-1:0] isum_q;
	logic signed [ACC_W-1:0] qsum_q;
	logic [IW-1:0]           sidx_q;
	logic [1:0]              symidx_q;
	logic [5:0]              pbyte_q;

	logic signed [ACC_W-1:0] isum_new;
	logic signed [ACC_W-1:0] qsum_new;
	logic [IW-1:0]           sidx_eff;
	logic [1:0]              symidx_eff;
	logic [5:0]              pbyte_eff;
	logic [CMPW-1:0]         sps_ext;
	logic [CMPW-1:0]         n_eff;
	logic [CMPW-1:0]         cnt_next;
	logic                    sym_end;
	logic [1:0]              sym;
	logic                    step_en;

	assign step_en = adv && ctl_s3.valid;

	always_comb begin
		sps_ext = CMPW'(sps);
		if (sps_ext == '0) begin
			n_eff = CMPW'(1);
		end else if (sps_ext > CMPW'(MAX_SPS)) begin
			n_eff = CMPW'(MAX_SPS);
		end else begin
			n_eff = sps_ext;
		end
		sidx_eff   = ctl_s3.start ? '0 : sidx_q;
		symidx_eff = ctl_s3.start ? '0 : symidx_q;
		pbyte_eff  = ctl_s3.start ? '0 : pbyte_q;
		isum_new   = (ctl_s3.start ? '0 : isum_q) + ACC_W'(prod_i_s3);
		qsum_new   = (ctl_s3.start ? '0 : qsum_q) + ACC_W'(prod_q_s3);
		cnt_next   = CMPW'(sidx_eff) + CMPW'(1);
		sym_end    = cnt_next >= n_eff;
		case ({isum_new[ACC_W-1], qsum_new[ACC_W-1]})
			2'b00:   sym = 2'd0;
			2'b10:   sym = 2'd1;
			2'b11:   sym = 2'd2;
			2'b01:   sym = 2'd3;
			default: sym = 2'd0;
		endcase
	end

	assign push      = step_en && sym_end && (symidx_eff == SYM_LAST);
	assign push_byte = {pbyte_eff, sym};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			isum_q   <= '0;
			qsum_q   <= '0;
			sidx_q   <= '0;
			symidx_q <= '0;
			pbyte_q  <= '0;
		end else if (step_en) begin
			if (!sym_end) begin
				isum_q   <= isum_new;
				qsum_q   <= qsum_new;
				sidx_q   <= cnt_next[IW-1:0];
				symidx_q <= symidx_eff;
				pbyte_q  <= pbyte_eff;
			end else begin
				isum_q <= '0;
				qsum_q <= '0;
				sidx_q <= '0;
				if (symidx_eff == SYM_LAST) begin
					symidx_q <= '0;
					pbyte_q  <= '0;
				end else begin
					symidx_q <= symidx_eff + 2'd1;
					pbyte_q  <= {pbyte_eff[3:0], sym};
				end
			end
		end
	end

`ifndef ASSERT_OFF
	a_push_needs_stage : assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (ctl_s3.valid && adv))
		else $error("byte pushed without a live sample");
	a_sums_clear_on_end : assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && sym_end) |=> (isum_q == '0 && qsum_q == '0 && sidx_q == '0))
		else $error("integrators not cleared at symbol end");
	a_partial_clear_on_push : assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (symidx_q == '0 && pbyte_q == '0))
		else $error("partial byte not cleared after output");
`endif

endmodule

// ===== sv/qpsk_correlation_demodulator_top.sv =====
// qpsk_correlation_demodulator_top: configuration registers, pipeline
// control and two-entry output queue; uses qpskcd_carrier, qpskcd_mixer,
// qpskcd_decide and qpskcd_pkg
//
//   channel  handshake              payload
//   in       in_valid / in_ready    sample[15:0] signed, start_req
//   out      out_valid / out_ready  data_byte[7:0]
//   cfg      cfg_we                 cfg_index[0], cfg_data[31:0]
//
// one sample accepted per cycle while the pipeline is not held; a byte is offered once its last sample
// has been integrated and the byte written into the output queue; pipeline: phase accumulator,
// rom read, multiply, integrate and decide; the whole pipeline holds only when the two-entry output
// queue is full and out_ready is low
// reset clears phase, integrators, counters and queue, and loads both registers
// with their defaults
module qpsk_correlation_demodulator_top
	import qpskcd_pkg::*;
#(
	parameter int unsigned TABLE_BITS = TABLE_BITS_DEF,
	parameter int unsigned MAX_SPS    = MAX_SPS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [IDX_W-1:0]           cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       start_req,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [BYTE_W-1:0]          data_byte
);

	logic [SPS_W-1:0]  sps_q;
	logic [STEP_W-1:0] step_q;

	logic                       adv;
	logic                       take;
	stage_ctl_t                 ctl_s2;
	stage_ctl_t                 ctl_s3;
	logic signed [SAMPLE_W-1:0] sample_s2;
	logic signed [TRIG_W-1:0]   cos_s2;
	logic signed [TRIG_W-1:0]   sin_s2;
	logic signed [PROD_W-1:0]   prod_i_s3;
	logic signed [PROD_W-1:0]   prod_q_s3;
	logic                       push;
	logic [BYTE_W-1:0]          push_byte;

	logic [1:0]        ocnt_q;
	logic [BYTE_W-1:0] obuf0_q;
	logic [BYTE_W-1:0] obuf1_q;
	logic              pop;

	assign out_valid = (ocnt_q != 2'd0);
	assign data_byte = obuf0_q;
	assign pop       = out_valid && out_ready;
	assign adv       = (ocnt_q != 2'd2) || out_ready;
	assign in_ready  = adv;
	assign take      = in_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sps_q  <= SPS_RESET;
			step_q <= STEP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SPS:  sps_q  <= cfg_data[SPS_W-1:0];
				REG_STEP: step_q <= cfg_data[STEP_W-1:0];
				default:  ;
			endcase
		end
	end

	qpskcd_carrier #(
		.TABLE_BITS(TABLE_BITS)
	) u_carrier (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.take      (take),
		.sample    (sample),
		.start_req (start_req),
		.step      (step_q),
		.ctl_s2    (ctl_s2),
		.sample_s2 (sample_s2),
		.cos_s2    (cos_s2),
		.sin_s2    (sin_s2)
	);

	qpskcd_mixer u_mixer (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.ctl_s2    (ctl_s2),
		.sample_s2 (sample_s2),
		.cos_s2    (cos_s2),
		.sin_s2    (sin_s2),
		.ctl_s3    (ctl_s3),
		.prod_i_s3 (prod_i_s3),
		.prod_q_s3 (prod_q_s3)
	);

	qpskcd_decide #(
		.MAX_SPS(MAX_SPS)
	) u_decide (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.ctl_s3    (ctl_s3),
		.prod_i_s3 (prod_i_s3),
		.prod_q_s3 (prod_q_s3),
		.sps       (sps_q),
		.push      (push),
		.push_byte (push_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ocnt_q <= '0;
		end else begin
			case ({push, pop})
				2'b10:   ocnt_q <= ocnt_q + 2'd1;
				2'b01:   ocnt_q <= ocnt_q - 2'd1;
				default: ocnt_q <= ocnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b11: begin
				if (ocnt_q == 2'd1) begin
					obuf0_q <= push_byte;
				end else begin
					obuf0_q <= obuf1_q;
					obuf1_q <= push_byte;
				end
			end
			2'b10: begin
				if (ocnt_q == 2'd0) begin
					obuf0_q <= push_byte;
				end else begin
					obuf1_q <= push_byte;
				end
			end
			2'b01: begin
				obuf0_q <= obuf1_q;
			end
			default: ;
		endcase
	end

`ifndef ASSERT_OFF
	a_queue_bound : assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q != 2'd3)
		else $error("output queue count out of range");
	a_no_push_when_full : assert property (@(posedge clk) disable iff (!arst_n)
		(push && ocnt_q == 2'd2) |-> pop)
		else $error("transaction pushed into a full output queue");
	a_full_blocks_input : assert property (@(posedge clk) disable iff (!arst_n)
		(ocnt_q == 2'd2 && !out_ready) |=> $stable(ocnt_q) || $past(push) == 1'b0)
		else $error("queue changed while stalled");
`endif

endmodule
